// ----- sv/chtb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chtb_pkg: shared types and constants of the hint table builder
// command and status codes, field widths and fixed limits
// ----------------------------------------------------------------------------
package chtb_pkg;

  localparam int unsigned HASH_W     = 14;
  localparam int unsigned NAME_LEN_W = 11;
  localparam int unsigned CURSOR_W   = 17;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned BUCKET_W   = 9;

  localparam logic [NAME_LEN_W-1:0] NAME_LEN_MAX = 11'd2047;
  localparam logic [BUCKET_W-1:0]   BUCKET_RESET = 9'd256;

  typedef enum logic [1:0] {
    CMD_NAME_BYTE = 2'd0,
    CMD_END_ENTRY = 2'd1,
    CMD_CLEAR     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_FULL     = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

endpackage
`default_nettype wire

// ----- sv/coalesced_hint_table_builder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coalesced_hint_table_builder: coalesced hash table placement engine
// hashes library names byte by byte and places each entry in a coalesced
// hash table held in one synchronous memory
// ----------------------------------------------------------------------------
// usage
//   input words are offered on start_i with command_i and its payload; a word
//   is taken at a clock edge with start_i high and busy_o low
//   command name byte: folds a nonzero byte into the running hash
//   command clear: sweeps the whole table with busy_o high
//   command end of entry: gives exactly one result word, marked by done_o for
//   one cycle with slot_o, name_offset_o, path_offset_o and status_o
// placement of an end of entry word
//   a bit-serial modulo of the 14-bit hash (one remainder bit per cycle), then
//   the home slot read and placement; a taken home slot adds the free slot scan
//   and the walk along the home chain, then the tail link; the result strobe
//   follows the last busy cycle; the single memory port (one read or one write
//   per cycle) sets the pace
// reset
//   clears the control state and then sweeps the table memory, one entry per
//   cycle over all SLOTS entries; busy_o stays high through the sweep
//   bucket_count returns to 256 and is written at any edge with cfg_we_i
// the receiver cannot stall: each result is shown for one cycle only
// ----------------------------------------------------------------------------
module coalesced_hint_table_builder
  import chtb_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [BUCKET_W-1:0]  cfg_wdata_i,
  // command channel
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [1:0]           command_i,
  input  wire logic [7:0]           name_byte_i,
  input  wire logic [15:0]          major_version_i,
  input  wire logic [9:0]           path_length_i,
  // result channel
  output logic                      done_o,
  output logic [7:0]                slot_o,
  output logic [OFF_W-1:0]          name_offset_o,
  output logic [OFF_W-1:0]          path_offset_o,
  output logic [1:0]                status_o
);

  // slot index width and a width that can also hold SLOTS itself
  localparam int unsigned SW   = $clog2(SLOTS);
  localparam int unsigned NBW  = $clog2(SLOTS + 1);
  localparam int unsigned DCW  = $clog2(HASH_W);

  localparam logic [SW-1:0]  LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [NBW-1:0] NB_MAX    = NBW'(SLOTS);

  // one table entry: occupied flag and chain link
  typedef struct packed {
    logic          used;
    logic          linked;
    logic [SW-1:0] next;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_HOME_RD,
    S_HOME_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_WALK_RD,
    S_WALK_CHK,
    S_LINK,
    S_PLACE
  } state_e;

  state_e                state_q;
  logic [BUCKET_W-1:0]   bucket_count_q;
  logic [HASH_W-1:0]     hash_q;
  logic [NAME_LEN_W-1:0] len_q;
  logic [CURSOR_W-1:0]   cursor_q;
  logic [NBW-1:0]        free_lo_q;   // every slot below is known to be used

  // per-entry working registers
  logic [NBW-1:0]        nb_q;
  logic [9:0]            plen_q;
  logic [HASH_W-1:0]     div_q;
  logic [DCW-1:0]        div_cnt_q;
  logic [NBW-1:0]        rem_q;
  logic [SW-1:0]         home_q;
  logic [SW-1:0]         place_q;
  logic                  at_home_q;
  logic [SW-1:0]         cur_q;
  logic [NBW-1:0]        scan_q;
  logic [SW-1:0]         clr_q;

  // result registers
  logic                  done_q;
  logic [7:0]            slot_q;
  logic [OFF_W-1:0]      noff_q;
  logic [OFF_W-1:0]      poff_q;
  logic [1:0]            status_q;

  // table memory, single port, registered read
  entry_t                entry_mem [SLOTS];
  entry_t                rd_q;
  logic                  mem_we;
  logic [SW-1:0]         mem_addr;
  entry_t                mem_wdata;

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  logic                  accept;
  logic [HASH_W-1:0]     byte_sx;
  logic [HASH_W-1:0]     hash_byte;
  logic [HASH_W-1:0]     major_mix;
  logic [HASH_W-1:0]     hash_end;
  logic [NBW-1:0]        nb_eff;
  logic [NBW:0]          rem_shift;
  logic [NBW:0]          rem_sub;
  logic [NBW-1:0]        rem_next;
  logic [CURSOR_W:0]     poff_full;
  logic                  offset_ovf;
  logic [CURSOR_W-1:0]   cursor_next;

  assign accept = start_i && (state_q == S_IDLE);

  // name byte taken as a signed char
  assign byte_sx   = {{(HASH_W - 8){name_byte_i[7]}}, name_byte_i};
  assign hash_byte = {hash_q[HASH_W-2:0], 1'b0} ^ byte_sx;

  // major * 257 kept to the hash width: major + (major << 8)
  assign major_mix = major_version_i[HASH_W-1:0] + {major_version_i[HASH_W-9:0], 8'h00};
  assign hash_end  = {hash_q[HASH_W-2:0], 1'b0} ^ major_mix;

  // bucket count clamped to 1..SLOTS
  always_comb begin
    if (bucket_count_q == '0) begin
      nb_eff = NBW'(1);
    end else if (32'(bucket_count_q) > SLOTS) begin
      nb_eff = NB_MAX;
    end else begin
      nb_eff = NBW'(bucket_count_q);
    end
  end

  // one restoring step of the modulo per cycle, remainder stays below nb
  assign rem_shift = {rem_q, div_q[HASH_W-1]};
  assign rem_sub   = rem_shift - {1'b0, nb_q};
  assign rem_next  = (rem_shift >= {1'b0, nb_q}) ? rem_sub[NBW-1:0] : rem_shift[NBW-1:0];

  // string offsets of the entry under construction
  assign poff_full   = (CURSOR_W + 1)'(cursor_q) + (CURSOR_W + 1)'(len_q) + (CURSOR_W + 1)'(1);
  assign offset_ovf  = cursor_q[CURSOR_W-1] || (poff_full > (CURSOR_W + 1)'(17'h0FFFF));
  assign cursor_next = CURSOR_W'(poff_full) + CURSOR_W'(plen_q) + CURSOR_W'(1);

  // --------------------------------------------------------------------------
  // memory port control
  // --------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = home_q;
    mem_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      S_HOME_RD: begin
        mem_addr = home_q;
      end
      S_SCAN_RD: begin
        mem_addr = scan_q[SW-1:0];
      end
      S_WALK_RD: begin
        mem_addr = cur_q;
      end
      S_LINK: begin
        // tail of the home chain now points at the new slot
        mem_we    = 1'b1;
        mem_addr  = cur_q;
        mem_wdata = '{used: 1'b1, linked: 1'b1, next: place_q};
      end
      S_PLACE: begin
        // a free slot never carries a link, so the new entry starts unlinked
        mem_we    = 1'b1;
        mem_addr  = place_q;
        mem_wdata = '{used: 1'b1, linked: 1'b0, next: '0};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_addr] <= mem_wdata;
    end
    rd_q <= entry_mem[mem_addr];
  end

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BUCKET_RESET;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // control sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      hash_q    <= '0;
      len_q     <= '0;
      cursor_q  <= '0;
      free_lo_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SW'(1);
          if (clr_q == LAST_SLOT) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            case (command_i)
              CMD_NAME_BYTE: begin
                // a zero byte cannot be part of a name
                if (name_byte_i != 8'h00) begin
                  hash_q <= hash_byte;
                  if (len_q != NAME_LEN_MAX) begin
                    len_q <= len_q + NAME_LEN_W'(1);
                  end
                end
              end
              CMD_END_ENTRY: begin
                nb_q      <= nb_eff;
                plen_q    <= path_length_i;
                div_q     <= hash_end;
                div_cnt_q <= '0;
                rem_q     <= '0;
                state_q   <= S_DIV;
              end
              CMD_CLEAR: begin
                hash_q    <= '0;
                len_q     <= '0;
                cursor_q  <= '0;
                free_lo_q <= '0;
                clr_q     <= '0;
                state_q   <= S_CLEAR;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_DIV: begin
          rem_q     <= rem_next;
          div_q     <= {div_q[HASH_W-2:0], 1'b0};
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == DCW'(HASH_W - 1)) begin
            home_q  <= rem_next[SW-1:0];
            state_q <= S_HOME_RD;
          end
        end

        S_HOME_RD: begin
          state_q <= S_HOME_CHK;
        end

        S_HOME_CHK: begin
          if (!rd_q.used) begin
            place_q   <= home_q;
            at_home_q <= 1'b1;
            state_q   <= S_DECIDE;
          end else begin
            at_home_q <= 1'b0;
            scan_q    <= free_lo_q;
            state_q   <= S_SCAN_RD;
          end
        end

        S_SCAN_RD: begin
          if (scan_q >= nb_q) begin
            // no free slot among the buckets in use
            done_q   <= 1'b1;
            slot_q   <= '0;
            noff_q   <= '0;
            poff_q   <= '0;
            status_q <= ST_FULL;
            hash_q   <= '0;
            len_q    <= '0;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_SCAN_CHK;
          end
        end

        S_SCAN_CHK: begin
          if (!rd_q.used) begin
            place_q <= scan_q[SW-1:0];
            state_q <= S_DECIDE;
          end else begin
            scan_q    <= scan_q + NBW'(1);
            free_lo_q <= scan_q + NBW'(1);
            state_q   <= S_SCAN_RD;
          end
        end

        S_DECIDE: begin
          if (offset_ovf) begin
            done_q   <= 1'b1;
            slot_q   <= '0;
            noff_q   <= '0;
            poff_q   <= '0;
            status_q <= ST_OVERFLOW;
            hash_q   <= '0;
            len_q    <= '0;
            state_q  <= S_IDLE;
          end else if (at_home_q) begin
            state_q <= S_PLACE;
          end else begin
            cur_q   <= home_q;
            state_q <= S_WALK_RD;
          end
        end

        S_WALK_RD: begin
          state_q <= S_WALK_CHK;
        end

        S_WALK_CHK: begin
          if (rd_q.linked) begin
            cur_q   <= rd_q.next;
            state_q <= S_WALK_RD;
          end else begin
            state_q <= S_LINK;
          end
        end

        S_LINK: begin
          state_q <= S_PLACE;
        end

        S_PLACE: begin
          done_q   <= 1'b1;
          slot_q   <= 8'(place_q);
          noff_q   <= OFF_W'(cursor_q);
          poff_q   <= OFF_W'(poff_full);
          status_q <= ST_PLACED;
          cursor_q <= cursor_next;
          hash_q   <= '0;
          len_q    <= '0;
          state_q  <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign slot_o        = slot_q;
  assign name_offset_o = noff_q;
  assign path_offset_o = poff_q;
  assign status_o      = status_q;

`ifndef SYNTHESIS
  // a result only ever closes a busy stretch
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without preceding work");

  // an accepted end of entry always starts the placement work
  a_end_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (command_i == CMD_END_ENTRY)) |=> busy_o)
    else $error("end of entry did not start placement");

  // the table is never written while the block reports idle
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("table write while idle");

  // failed placements carry zero slot and offsets
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_PLACED)) |->
      ((slot_o == 8'h00) && (name_offset_o == '0) && (path_offset_o == '0)))
    else $error("failed placement with nonzero payload");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/chtb_placement_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtb_placement_checker: placement predictor and result checker
// follows every accepted command word and bucket write, predicts the slot,
// string offsets and status of each entry and compares them with the
// result words of the builder
// ----------------------------------------------------------------------------
module chtb_placement_checker
  import chtb_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BUCKET_W-1:0] cfg_wdata_i,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [1:0]          command_i,
  input  logic [7:0]          name_byte_i,
  input  logic [15:0]         major_version_i,
  input  logic [9:0]          path_length_i,
  input  logic                done_i,
  input  logic [7:0]          slot_i,
  input  logic [OFF_W-1:0]    name_offset_i,
  input  logic [OFF_W-1:0]    path_offset_i,
  input  logic [1:0]          status_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_o,
  output int unsigned         placed_count_o,
  output int unsigned         full_count_o,
  output int unsigned         overflow_count_o
);

  localparam int unsigned HASH_MASK = 32'h3fff;

  typedef struct packed {
    logic [7:0]       slot;
    logic [OFF_W-1:0] name_off;
    logic [OFF_W-1:0] path_off;
    status_e          status;
  } placement_t;

  // shadow copy of the table and counters
  logic [BUCKET_W-1:0]   buckets = BUCKET_RESET;
  bit                    slot_taken [SLOTS];
  logic [8:0]            chain_link [SLOTS];
  logic [HASH_W-1:0]     hash;
  logic [NAME_LEN_W-1:0] name_len;
  int unsigned           cursor;

  placement_t  expected_placements [$];
  int unsigned mismatches = 0;
  int unsigned waiting = 0;
  int unsigned placed_seen = 0;
  int unsigned full_seen = 0;
  int unsigned overflow_seen = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = waiting;
  assign placed_count_o   = placed_seen;
  assign full_count_o     = full_seen;
  assign overflow_count_o = overflow_seen;

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_taken[i] = 1'b0;
      chain_link[i] = '1;
    end
    hash     = '0;
    name_len = '0;
    cursor   = 0;
  endfunction

  // zero bytes never reach the hash or the length
  function automatic void fold_name_byte(logic [7:0] b);
    if (b != 8'd0) begin
      hash = {hash[HASH_W-2:0], 1'b0} ^ {{(HASH_W-8){b[7]}}, b};
      if (name_len != NAME_LEN_MAX) name_len = name_len + 1'b1;
    end
  endfunction

  function automatic placement_t place_entry(logic [15:0] major, logic [9:0] plen);
    int unsigned nb, mixed, home, spot, noff, poff, cur, hops;
    placement_t r;
    nb = (buckets == 0) ? 1 : ((buckets > SLOTS) ? SLOTS : buckets);
    mixed = ((32'(hash) << 1) ^ (32'(major) * 257)) & HASH_MASK;
    home = mixed % nb;
    spot = home;
    noff = cursor;
    poff = cursor + name_len + 1;
    r.status = ST_PLACED;
    if (slot_taken[home]) begin
      spot = 0;
      while (spot < nb && slot_taken[spot]) spot++;
      if (spot == nb) r.status = ST_FULL;
    end
    // full wins over overflow; poff is never below noff
    if (r.status == ST_PLACED && poff > 32'hffff) r.status = ST_OVERFLOW;
    if (r.status == ST_PLACED) begin
      if (spot != home) begin
        cur  = home;
        hops = 0;
        while (chain_link[cur] < SLOTS && hops < SLOTS) begin
          cur = chain_link[cur];
          hops++;
        end
        chain_link[cur] = spot[8:0];
      end
      slot_taken[spot] = 1'b1;
      cursor     = poff + plen + 1;
      r.slot     = spot[7:0];
      r.name_off = noff[OFF_W-1:0];
      r.path_off = poff[OFF_W-1:0];
    end else begin
      r.slot     = '0;
      r.name_off = '0;
      r.path_off = '0;
    end
    hash     = '0;
    name_len = '0;
    return r;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    placement_t want;
    if (!rst_ni) begin
      buckets = BUCKET_RESET;
      clear_table();
      expected_placements.delete();
      waiting = 0;
    end else begin
      // result words belong to earlier entries, so check before predicting
      if (done_i === 1'b1) begin
        if (expected_placements.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word slot %0d name %0d path %0d status %0d",
                   $time, slot_i, name_offset_i, path_offset_i, status_i);
        end else begin
          want = expected_placements.pop_front();
          check_field("slot", want.slot, slot_i);
          check_field("name offset", want.name_off, name_offset_i);
          check_field("path offset", want.path_off, path_offset_i);
          check_field("status", want.status, status_i);
          case (want.status)
            ST_PLACED: placed_seen++;
            ST_FULL:   full_seen++;
            default:   overflow_seen++;
          endcase
        end
      end
      if (cfg_we_i) buckets = cfg_wdata_i;
      if (start_i && !busy_i) begin
        case (command_i)
          CMD_NAME_BYTE: fold_name_byte(name_byte_i);
          CMD_END_ENTRY: expected_placements.push_back(
                           place_entry(major_version_i, path_length_i));
          CMD_CLEAR:     clear_table();
          default: ;
        endcase
      end
      waiting = expected_placements.size();
    end
  end

endmodule

// ----- tb/sv/coalesced_hint_table_builder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalesced_hint_table_builder_test: testbench of the hint table builder
// drives name bytes, entry ends, clears and the unused command code with
// random gaps, walks the bucket count through many settings and leaves the
// prediction and result checking to the placement checker
// ----------------------------------------------------------------------------
module coalesced_hint_table_builder_test;
  import chtb_pkg::*;

  localparam int unsigned SLOTS = 256;
  // the fourth command code, which the builder must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // a clear sweep may still run after the last result word
  localparam int unsigned SETTLE_CYCLES = SLOTS + 64;
  // worst entry: full scan plus full chain walk
  localparam int unsigned DRAIN_CYCLES = 4 * SLOTS + 200;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned RANDOM_WORDS = 1450;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [BUCKET_W-1:0] cfg_wdata_i;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          command_i;
  logic [7:0]          name_byte_i;
  logic [15:0]         major_version_i;
  logic [9:0]          path_length_i;
  logic                done_o;
  logic [7:0]          slot_o;
  logic [OFF_W-1:0]    name_offset_o;
  logic [OFF_W-1:0]    path_offset_o;
  logic [1:0]          status_o;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned placed_count;
  int unsigned full_count;
  int unsigned overflow_count;

  coalesced_hint_table_builder #(.SLOTS(SLOTS)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .name_byte_i    (name_byte_i),
    .major_version_i(major_version_i),
    .path_length_i  (path_length_i),
    .done_o         (done_o),
    .slot_o         (slot_o),
    .name_offset_o  (name_offset_o),
    .path_offset_o  (path_offset_o),
    .status_o       (status_o)
  );

  chtb_placement_checker #(.SLOTS(SLOTS)) placement_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .command_i       (command_i),
    .name_byte_i     (name_byte_i),
    .major_version_i (major_version_i),
    .path_length_i   (path_length_i),
    .done_i          (done_o),
    .slot_i          (slot_o),
    .name_offset_i   (name_offset_o),
    .path_offset_i   (path_offset_o),
    .status_i        (status_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .placed_count_o  (placed_count),
    .full_count_o    (full_count),
    .overflow_count_o(overflow_count)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // watchdog: any accepted command word or result word counts as progress
  int unsigned stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o === 1'b1 || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus bookkeeping
  bit          no_gaps = 1'b0;
  int unsigned useful_words = 0;
  int unsigned name_words = 0;
  int unsigned entry_words = 0;
  int unsigned clear_words = 0;
  int unsigned unused_words = 0;
  int unsigned bucket_writes = 0;

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(logic [1:0] cmd, logic [7:0] b, logic [15:0] major,
                           logic [9:0] plen);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i         <= 1'b1;
    command_i       <= cmd;
    name_byte_i     <= b;
    major_version_i <= major;
    path_length_i   <= plen;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
    case (cmd)
      CMD_NAME_BYTE: name_words++;
      CMD_END_ENTRY: entry_words++;
      CMD_CLEAR:     clear_words++;
      default:       unused_words++;
    endcase
    // ignored words do not count toward the random budget
    if (cmd != CMD_UNUSED && !(cmd == CMD_NAME_BYTE && b == 8'd0)) useful_words++;
  endtask

  // zero bytes sprinkled in only where asked
  task automatic send_entry(int unsigned len, bit with_zeros, logic [15:0] major,
                            logic [9:0] plen);
    logic [7:0] b;
    repeat (len) begin
      b = 8'($urandom_range(1, 255));
      if (with_zeros && $urandom_range(0, 19) == 0) b = 8'd0;
      send_word(CMD_NAME_BYTE, b, 16'($urandom), 10'($urandom));
    end
    send_word(CMD_END_ENTRY, 8'($urandom), major, plen);
  endtask

  // hold off until every result word is in and any clear sweep is over
  task automatic settle();
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (busy_o !== 1'b0) @(negedge clk_i);
  endtask

  task automatic set_buckets(logic [BUCKET_W-1:0] count);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    bucket_writes++;
  endtask

  // mostly small tables so collisions, chains and full tables come often
  function automatic logic [BUCKET_W-1:0] pick_buckets();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 9'd1;
      6:       return BUCKET_W'($urandom_range(17, 255));
      7:       return 9'd256;
      8:       return BUCKET_W'($urandom_range(257, 511));
      9:       return BUCKET_W'($urandom_range(2, 8));
      default: return BUCKET_W'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic int unsigned pick_name_len();
    case ($urandom_range(0, 9))
      0:       return 0;
      7, 8:    return $urandom_range(7, 20);
      9:       return $urandom_range(21, 40);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [9:0] pick_path_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    int unsigned mark;
    int unsigned noise;
    int unsigned entries;

    // every input known from time zero
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    start_i         = 1'b0;
    command_i       = CMD_NAME_BYTE;
    name_byte_i     = '0;
    major_version_i = '0;
    path_length_i   = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words at the reset bucket count of 256
    // zero byte is ignored, then both sign cases of a byte and the extremes
    send_word(CMD_NAME_BYTE, 8'h00, '1, '1);
    send_word(CMD_NAME_BYTE, 8'h7f, '0, '0);
    send_word(CMD_NAME_BYTE, 8'h80, '1, '1);
    send_word(CMD_NAME_BYTE, 8'hff, '0, '0);
    send_word(CMD_NAME_BYTE, 8'h01, '1, '1);
    send_word(CMD_END_ENTRY, 8'hff, 16'hffff, 10'd1023);
    // empty names with the same version collide on one home slot and chain up
    send_word(CMD_END_ENTRY, 8'h00, 16'h0000, 10'd0);
    send_word(CMD_END_ENTRY, 8'hff, 16'h0000, 10'd0);
    send_word(CMD_END_ENTRY, 8'h00, 16'h0000, 10'd0);
    send_word(CMD_UNUSED, 8'hff, 16'hffff, 10'd1023);
    send_word(CMD_CLEAR, 8'h00, 16'h0000, 10'd0);
    // home slot free again after the clear
    send_word(CMD_END_ENTRY, 8'h00, 16'h0000, 10'd0);

    // a count of zero acts as one bucket, and slot 0 is already taken: both entries find it full
    set_buckets('0);
    send_word(CMD_END_ENTRY, 8'h55, 16'h1234, 10'd5);
    send_word(CMD_END_ENTRY, 8'haa, 16'h4321, 10'd7);
    send_word(CMD_CLEAR, 8'hff, 16'hffff, 10'd1023);

    // a count above the table size acts as the table size
    set_buckets('1);
    send_word(CMD_NAME_BYTE, 8'h41, 16'h0000, 10'd0);
    send_word(CMD_NAME_BYTE, 8'hc3, 16'h0000, 10'd0);
    send_word(CMD_END_ENTRY, 8'h00, 16'h8001, 10'd512);

    // random phases: each one a new bucket count, mostly on a cleared table
    mark = useful_words;
    while (useful_words - mark < RANDOM_WORDS) begin
      set_buckets(pick_buckets());
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        send_word(CMD_CLEAR, 8'($urandom), 16'($urandom), 10'($urandom));
      end
      entries = $urandom_range(4, 30);
      repeat (entries) begin
        noise = $urandom_range(0, 99);
        if (noise < 4) begin
          send_word(CMD_CLEAR, 8'($urandom), 16'($urandom), 10'($urandom));
        end else if (noise < 8) begin
          send_word(CMD_UNUSED, 8'($urandom), 16'($urandom), 10'($urandom));
        end
        send_entry(pick_name_len(), 1'b1, 16'($urandom), pick_path_len());
      end
    end

    // fill 64 buckets with empty names and the longest paths so the string
    // table runs past 16 bits exactly when the table fills: full must win
    set_buckets(9'd64);
    no_gaps = 1'b0;
    send_word(CMD_CLEAR, 8'($urandom), 16'($urandom), 10'($urandom));
    repeat (64) send_entry(0, 1'b0, 16'($urandom), 10'd1023);
    repeat (2) send_entry(0, 1'b0, 16'($urandom), 10'd1023);
    // one more bucket frees a slot, but the offsets no longer fit
    set_buckets(9'd65);
    repeat (3) send_entry($urandom_range(0, 8), 1'b0, 16'($urandom), pick_path_len());

    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d name bytes, %0d entry ends, %0d clears, %0d unused, %0d bucket writes",
             name_words, entry_words, clear_words, unused_words, bucket_writes);
    $display("results checked: %0d placed, %0d table full, %0d offset overflow",
             placed_count, full_count, overflow_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
